[hw/rtl/sfs_pkg.sv]
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

  // Field widths of the request, result and configuration channels.
  localparam int ACTION_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 4;
  localparam int FC_W       = 5;
  localparam int MODE_W     = 2;
  localparam int DDUR_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Frame counters hold any count up to 256 frames.
  localparam int CNT_W = 9;

  localparam logic [DDUR_W-1:0] DEFAULT_DURATION_RST = 16'd83;
  localparam logic [DDUR_W-1:0] FALLBACK_DURATION    = 16'd83;

  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DURATION = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } seq_state_t;

endpackage

[hw/rtl/sfs_dur_mem.sv]
// Frame duration memory with one write port, one registered read port and per-entry valid bits.
module sfs_dur_mem
  import sfs_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DW-1:0]    rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_q[rd_addr];
    end
  end

  // An entry never written since reset reads as zero, which selects the default duration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[hw/rtl/sfs_mod_unit.sv]
// Restoring remainder unit that retires one dividend bit per cycle.
module sfs_mod_unit
  import sfs_pkg::*;
#(
  parameter int DVD_W = 32,
  parameter int DIV_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [DIV_W-1:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = trial - {1'b0, div_r};
  assign fits    = trial >= {1'b0, div_r};
  // The partial remainder stays below the divisor, so both choices fit in DIV_W bits.
  assign rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CW'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> rem_r < div_r)
    else $error("remainder not below divisor at completion");
  assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("remainder unit started while busy");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |=> busy_r || done_r)
    else $error("remainder unit left busy without completing");

endmodule

[hw/rtl/sprite_frame_sequencer.sv]
// Top level of the sprite frame sequencer: request decode, frame sequencer and result register.
//
// Each request advances or sets the clip time, loads one frame duration or does nothing,
// after which the current frame index is recomputed and returned as one result. The number
// of active frames is the frame count, at most MAX_FRAMES. With no clip the result is loaded
// without a sweep. Otherwise the single read port of the duration memory is swept once to
// total the clip and once more to find the frame; in once and hold modes the second sweep is
// skipped when the time is already past the end of the clip, and in loop mode the remainder
// unit, which retires one time bit per cycle, runs between the two sweeps. The result is
// loaded once the output register is free, and the next request is accepted in the cycle
// after that. The next request is taken while a finished result still waits on the output.
// The duration memory needs no clearing pass after reset.
module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES    = 16,
  parameter int TIME_BITS     = 32,
  parameter int DURATION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] action, [5:2] frame_slot, [37:6] value, [39:38] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] frame_index, [4] finished, [7:5] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int TK_W  = (DURATION_BITS > DDUR_W) ? DURATION_BITS : DDUR_W;
  localparam int TOT_W = TK_W + CNT_W;
  localparam int CMP_W = (TIME_BITS > TOT_W) ? TIME_BITS : TOT_W;
  localparam int EXT_W = ((TIME_BITS > VALUE_W) ? TIME_BITS : VALUE_W) + 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_FRAMES);
  localparam logic [EXT_W-1:0] TMAX_EXT =
    {{(EXT_W-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
  localparam logic [VALUE_W:0] DMAX_EXT =
    {{(VALUE_W+1-DURATION_BITS){1'b0}}, {DURATION_BITS{1'b1}}};

  // Configuration registers
  logic [FC_W-1:0]   frame_count_r;
  logic [MODE_W-1:0] loop_mode_r;
  logic [DDUR_W-1:0] default_duration_r;

  // Sequencer state
  seq_state_t         state_r, state_nxt;
  logic [TIME_BITS-1:0] local_time_r, local_time_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]   rd_idx_r;
  logic               rd_pend_r;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [CMP_W-1:0]   t_r, t_nxt;
  logic [CNT_W-1:0]   res_idx_r, res_idx_nxt;
  logic               res_fin_r, res_fin_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic               out_fin_r, out_fin_nxt;

  // Request fields
  logic [ACTION_W-1:0] in_action;
  logic [SLOT_W-1:0]   in_slot;
  logic [VALUE_W-1:0]  in_value;
  logic                in_accept;

  logic [CNT_W-1:0]         fc_ext;
  logic [CNT_W-1:0]         n_act;
  logic [CNT_W-1:0]         last;
  logic [CNT_W-1:0]         slot_ext;
  logic                     slot_ok;
  logic [DURATION_BITS-1:0] dur_sat;
  logic [EXT_W-1:0]         adv_sum;
  logic [EXT_W-1:0]         val_ext;
  logic [TIME_BITS-1:0]     adv_time;
  logic [TIME_BITS-1:0]     set_time;

  logic                     mem_we;
  logic                     rd_en;
  logic [DURATION_BITS-1:0] rd_data;
  logic [DDUR_W-1:0]        dflt_dur;
  logic [TK_W-1:0]          tick;
  logic [TOT_W-1:0]         total_sum;
  logic [CMP_W-1:0]         tick_cmp;
  logic                     found;

  logic                 mod_start;
  logic                 mod_busy;
  logic                 mod_done;
  logic [TOT_W-1:0]     mod_rem;

  assign in_action = in_tdata[1:0];
  assign in_slot   = in_tdata[5:2];
  assign in_value  = in_tdata[37:6];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Counts above the memory depth fall back to the full depth.
  assign fc_ext   = CNT_W'(frame_count_r);
  assign n_act    = (fc_ext > MAX_N) ? MAX_N : fc_ext;
  assign last     = n_act - 1'b1;
  assign slot_ext = CNT_W'(in_slot);
  assign slot_ok  = slot_ext < MAX_N;

  assign dur_sat  = ({1'b0, in_value} > DMAX_EXT) ? {DURATION_BITS{1'b1}}
                                                  : in_value[DURATION_BITS-1:0];
  assign adv_sum  = EXT_W'(local_time_r) + EXT_W'(in_value);
  assign val_ext  = EXT_W'(in_value);
  assign adv_time = (adv_sum > TMAX_EXT) ? {TIME_BITS{1'b1}} : adv_sum[TIME_BITS-1:0];
  assign set_time = (val_ext > TMAX_EXT) ? {TIME_BITS{1'b1}} : val_ext[TIME_BITS-1:0];

  assign mem_we = in_accept && (in_action == ACT_LOAD) && slot_ok;
  assign rd_en  = ((state_r == ST_SUM) && (addr_r < n_act)) ||
                  ((state_r == ST_WALK) && (addr_r < last));

  // A stored duration of zero selects the default, and a zero default selects the fallback.
  assign dflt_dur  = (default_duration_r != '0) ? default_duration_r : FALLBACK_DURATION;
  assign tick      = (rd_data != '0) ? TK_W'(rd_data) : TK_W'(dflt_dur);
  assign total_sum = total_r + TOT_W'(tick);
  assign tick_cmp  = CMP_W'(tick);
  assign found     = t_r < tick_cmp;

  assign mod_start = (state_r == ST_SUM) && !rd_en && (loop_mode_r == MODE_LOOP);

  sfs_dur_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW),
    .DW    (DURATION_BITS)
  ) u_dur_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_data (dur_sat),
    .rd_en   (rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  sfs_mod_unit #(
    .DVD_W (TIME_BITS),
    .DIV_W (TOT_W)
  ) u_mod_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (local_time_r),
    .divisor   (total_sum),
    .busy      (mod_busy),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    local_time_nxt = local_time_r;
    addr_nxt       = rd_en ? addr_r + 1'b1 : addr_r;
    total_nxt      = total_r;
    t_nxt          = t_r;
    res_idx_nxt    = res_idx_r;
    res_fin_nxt    = res_fin_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_idx_nxt    = out_idx_r;
    out_fin_nxt    = out_fin_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_action)
            ACT_ADVANCE: begin
              if (n_act != '0) begin
                local_time_nxt = adv_time;
              end
            end
            ACT_SET: local_time_nxt = set_time;
            default: local_time_nxt = local_time_r;
          endcase
          addr_nxt  = '0;
          total_nxt = '0;
          if (n_act == '0) begin
            res_idx_nxt = '0;
            res_fin_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (rd_pend_r) begin
          total_nxt = total_sum;
        end
        // The last read returns in the cycle after the final address was issued.
        if (!rd_en) begin
          addr_nxt = '0;
          if (loop_mode_r == MODE_LOOP) begin
            state_nxt = ST_MOD;
          end else if (CMP_W'(local_time_r) >= CMP_W'(total_sum)) begin
            res_idx_nxt = last;
            res_fin_nxt = (loop_mode_r == MODE_ONCE);
            state_nxt   = ST_DONE;
          end else begin
            t_nxt       = CMP_W'(local_time_r);
            res_fin_nxt = 1'b0;
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_MOD: begin
        addr_nxt = '0;
        if (mod_done) begin
          t_nxt       = CMP_W'(mod_rem);
          res_fin_nxt = 1'b0;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_pend_r && found) begin
          res_idx_nxt = rd_idx_r;
          state_nxt   = ST_DONE;
        end else begin
          if (rd_pend_r) begin
            t_nxt = t_r - tick_cmp;
          end
          if (!rd_pend_r && !rd_en) begin
            res_idx_nxt = last;
            state_nxt   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_idx_nxt    = res_idx_r[INDEX_W-1:0];
          out_fin_nxt    = res_fin_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      local_time_r <= '0;
      addr_r       <= '0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      local_time_r <= local_time_nxt;
      addr_r       <= addr_nxt;
      rd_pend_r    <= rd_en;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= addr_r;
    total_r   <= total_nxt;
    t_r       <= t_nxt;
    res_idx_r <= res_idx_nxt;
    res_fin_r <= res_fin_nxt;
    out_idx_r <= out_idx_nxt;
    out_fin_r <= out_fin_nxt;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r      <= '0;
      loop_mode_r        <= MODE_ONCE;
      default_duration_r <= DEFAULT_DURATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT:      frame_count_r      <= cfg_data[FC_W-1:0];
        CFG_LOOP_MODE:        loop_mode_r        <= cfg_data[MODE_W-1:0];
        CFG_DEFAULT_DURATION: default_duration_r <= cfg_data;
        default:              frame_count_r      <= frame_count_r;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-INDEX_W-1){1'b0}}, out_fin_r, out_idx_r};

  assert property (@(posedge clk) disable iff (!rst_n) mod_done |-> state_r == ST_MOD)
    else $error("remainder completed outside the remainder phase");
  assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> !in_tready)
    else $error("request taken while the previous one is still in work");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_WALK) && rd_pend_r |-> rd_idx_r < last)
    else $error("frame search read beyond the last frame");
  assert property (@(posedge clk) disable iff (!rst_n) mod_busy |-> state_r == ST_MOD)
    else $error("remainder unit busy outside the remainder phase");

endmodule

[bench/sfs_result_checker.sv]
// Result checker of the sprite frame sequencer: clip state predictor and per-result compare.
module sfs_result_checker
  import sfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int NUM_SLOTS = 16;

  typedef struct packed {
    logic [INDEX_W-1:0] frame_index;
    logic               finished;
  } frame_res_t;

  // Shadow copy of the clip state and registers.
  logic [FC_W-1:0]   clip_frames;
  logic [MODE_W-1:0] play_mode;
  logic [DDUR_W-1:0] dflt_len;
  logic [31:0]       clip_time;
  logic [15:0]       frame_len [NUM_SLOTS];

  frame_res_t frames_due [$];
  frame_res_t want;
  frame_res_t got;
  int         err_cnt = 0;

  assign mismatches = err_cnt;

  function automatic longint unsigned ticks_of(input int i);
    if (frame_len[i] != 0) return frame_len[i];
    return (dflt_len != 0) ? dflt_len : FALLBACK_DURATION;
  endfunction

  // Applies one request to the shadow state and returns the frame it selects.
  function automatic frame_res_t step_clip(input logic [ACTION_W-1:0] act,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [VALUE_W-1:0] val);
    int                n;
    int                last;
    longint unsigned   total;
    longint unsigned   t;
    longint unsigned   d;
    bit                found;
    frame_res_t        r;
    n = (clip_frames > NUM_SLOTS) ? NUM_SLOTS : int'(clip_frames);
    r = '0;
    case (act)
      ACT_ADVANCE: begin
        if (n != 0 && val != 0)
          clip_time = (val > (32'hFFFF_FFFF - clip_time)) ? 32'hFFFF_FFFF : clip_time + val;
      end
      ACT_SET: clip_time = val;
      ACT_LOAD: frame_len[slot] = (val > 32'h0000_FFFF) ? 16'hFFFF : val[15:0];
      default: ;
    endcase
    if (n != 0) begin
      last = n - 1;
      total = 0;
      for (int i = 0; i < n; i++) total += ticks_of(i);
      t = clip_time;
      found = 1'b0;
      if (play_mode == MODE_LOOP) begin
        t = t % total;
      end else if (t >= total) begin
        // Past the end of the clip: hold on the last frame.
        r.frame_index = 4'(last);
        found = 1'b1;
        if (play_mode == MODE_ONCE) r.finished = 1'b1;
      end
      if (!found) begin
        r.frame_index = 4'(last);
        for (int i = 0; i < last; i++) begin
          d = ticks_of(i);
          if (!found) begin
            if (t < d) begin
              r.frame_index = 4'(i);
              found = 1'b1;
            end else begin
              t -= d;
            end
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clip_frames = '0;
      play_mode   = MODE_ONCE;
      dflt_len    = DEFAULT_DURATION_RST;
      clip_time   = '0;
      for (int i = 0; i < NUM_SLOTS; i++) frame_len[i] = '0;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_COUNT:      clip_frames = cfg_data[FC_W-1:0];
          CFG_LOOP_MODE:        play_mode   = cfg_data[MODE_W-1:0];
          CFG_DEFAULT_DURATION: dflt_len    = cfg_data[DDUR_W-1:0];
          default: ;
        endcase
      end
      // The result of a request is registered and never appears at the edge that accepts it, so
      // results are taken before the request accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got.frame_index = out_tdata[3:0];
        got.finished    = out_tdata[4];
        if (frames_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: frame_index %0d finished %0d",
                     got.frame_index, got.finished);
        end else begin
          want = frames_due.pop_front();
          if (got.frame_index !== want.frame_index || got.finished !== want.finished) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("result mismatch: expected frame_index %0d finished %0d, got %0d %0d",
                       want.frame_index, want.finished, got.frame_index, got.finished);
          end
        end
      end
      if (in_tvalid && in_tready)
        frames_due.push_back(step_clip(in_tdata[1:0], in_tdata[5:2], in_tdata[37:6]));
    end
    outstanding <= frames_due.size();
  end

endmodule

[bench/testbench.sv]
// Top of the sprite frame sequencer bench: clock, reset, request stimulus and verdict.
module testbench;
  import sfs_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;
  localparam int SETTLE = 100;
  localparam int TARGET_ITEMS = 1750;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;

  int gap_level = 0;
  int stall_level = 0;
  int burst_left = 0;
  int ready_run = 0;
  int sent = 0;

  always #10 clk = ~clk;

  sprite_frame_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sfs_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver readiness runs in stretches whose mix depends on the stall level.
  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (stall_level == 0) begin
      out_tready <= 1'b1;
      ready_run  <= $urandom_range(4, 40);
    end else if ($urandom_range(0, 9) < 2 * stall_level) begin
      out_tready <= 1'b0;
      ready_run  <= $urandom_range(0, 3 * stall_level);
    end else begin
      out_tready <= 1'b1;
      ready_run  <= $urandom_range(0, 6);
    end
  end

  task automatic send_req(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
                          input logic [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_level != 0) begin
        gap = $urandom_range(1, 4 * gap_level);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, val, slot, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic setup_clip(input logic [FC_W-1:0] fc, input logic [MODE_W-1:0] mode,
                            input logic [DDUR_W-1:0] dd);
    write_reg(CFG_FRAME_COUNT, {11'd0, fc});
    write_reg(CFG_LOOP_MODE, {14'd0, mode});
    write_reg(CFG_DEFAULT_DURATION, dd);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_req();
    int                   r;
    logic [ACTION_W-1:0]  act;
    logic [VALUE_W-1:0]   val;
    r = $urandom_range(0, 99);
    act = (r < 45) ? ACT_ADVANCE : (r < 65) ? ACT_SET : (r < 93) ? ACT_LOAD : ACT_NOP;
    r = $urandom_range(0, 99);
    case (act)
      ACT_ADVANCE: val = (r < 10) ? 32'd0 : (r < 20) ? $urandom() :
                         (r < 25) ? 32'hFFFF_FFFF : $urandom_range(1, 150);
      ACT_SET:     val = (r < 15) ? $urandom() : (r < 20) ? 32'hFFFF_FFFF :
                         $urandom_range(0, 1500);
      ACT_LOAD:    val = (r < 15) ? 32'd0 : (r < 25) ? $urandom() :
                         (r < 30) ? 32'h0000_FFFF : $urandom_range(1, 120);
      default:     val = $urandom();
    endcase
    send_req(act, 4'($urandom_range(0, 15)), val);
  endtask

  initial begin
    int               r;
    int               n_items;
    logic [FC_W-1:0]  fc;
    logic [DDUR_W-1:0] dd;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no clip, so advances leave the time alone.
    stall_level = 1;
    send_req(ACT_ADVANCE, 4'd0, 32'd1000);
    send_req(ACT_SET, 4'd7, 32'hFFFF_FFFF);
    send_req(ACT_LOAD, 4'd15, 32'hFFFF_FFFF);
    send_req(ACT_LOAD, 4'd0, 32'd5);
    send_req(ACT_NOP, 4'd9, 32'hA5A5_5A5A);
    drain();

    // Zero default duration falls back to the built-in one.
    setup_clip(5'd4, MODE_ONCE, 16'd0);
    send_req(ACT_SET, 4'd0, 32'd0);
    send_req(ACT_ADVANCE, 4'd0, 32'd0);
    send_req(ACT_ADVANCE, 4'd0, 32'd7);
    send_req(ACT_SET, 4'd0, 32'd253);
    send_req(ACT_SET, 4'd0, 32'd254);
    send_req(ACT_ADVANCE, 4'd0, 32'hFFFF_FFFF);
    send_req(ACT_NOP, 4'd0, 32'd0);
    drain();

    gap_level = 2;
    setup_clip(5'd16, MODE_LOOP, 16'hFFFF);
    send_req(ACT_SET, 4'd0, 32'hFFFF_FFFF);
    send_req(ACT_ADVANCE, 4'd0, 32'd1);
    send_req(ACT_LOAD, 4'd3, 32'h0001_0000);
    send_req(ACT_SET, 4'd0, 32'd1_000_000);
    drain();

    // Frame counts beyond the table size use the whole table.
    setup_clip(5'd31, MODE_PINGPONG, 16'd1);
    send_req(ACT_SET, 4'd0, 32'd100);
    send_req(ACT_ADVANCE, 4'd0, 32'hFFFF_FFFF);
    send_req(ACT_LOAD, 4'd15, 32'd0);
    drain();

    setup_clip(5'd1, MODE_HOLD, 16'd2);
    send_req(ACT_SET, 4'd0, 32'd0);
    send_req(ACT_ADVANCE, 4'd0, 32'd3);
    drain();

    while (sent < TARGET_ITEMS) begin
      r = $urandom_range(0, 19);
      fc = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
           (r < 4) ? 5'($urandom_range(9, 16)) : 5'($urandom_range(1, 8));
      r = $urandom_range(0, 9);
      dd = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'($urandom_range(1, 65535)) :
           16'($urandom_range(1, 60));
      gap_level = $urandom_range(0, 3);
      stall_level = $urandom_range(0, 3);
      burst_left = 0;
      setup_clip(fc, 2'($urandom_range(0, 3)), dd);
      n_items = $urandom_range(30, 100);
      repeat (n_items) random_req();
      drain();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
